[rtl/core/sab_pkg.sv]
// Shared types and constants for the saturating additive blitter.
// No dependencies.
`default_nettype none
package sab_pkg;
  localparam int unsigned DestWords   = 65536;
  localparam int unsigned SourceWords = 16384;
  localparam int unsigned DestAw      = $clog2(DestWords);
  localparam int unsigned SrcAw       = $clog2(SourceWords);
  localparam int unsigned PixW        = 32;
  localparam int unsigned PitchW      = 11;
  localparam int unsigned SideW       = 8;
  localparam int unsigned CountW      = 16;
  localparam logic [SideW-1:0]  MaxSide      = 8'd255;
  localparam logic [PitchW-1:0] DestPitchRst = 11'd256;
  localparam int unsigned QDepth      = 2;

  typedef enum logic [1:0] {
    ACT_WR_SRC = 2'd0,
    ACT_WR_DST = 2'd1,
    ACT_BLIT   = 2'd2,
    ACT_RD_DST = 2'd3
  } action_e;

  typedef struct packed {
    action_e           action;
    logic [15:0]       address;
    logic [PixW-1:0]   data;
    logic [SrcAw-1:0]  src_origin;
    logic [DestAw-1:0] dst_start;
    logic [SideW-1:0]  width;
    logic [SideW-1:0]  rows;
    logic [PitchW-1:0] src_pitch;
    logic [CountW-1:0] count;
  } cmd_t;

  function automatic logic [PixW-1:0] add_sat(input logic [PixW-1:0] a,
                                              input logic [PixW-1:0] b);
    logic [PixW-1:0] r;
    logic [8:0] s;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      s = {1'b0, a[i*8 +: 8]} + {1'b0, b[i*8 +: 8]};
      r[i*8 +: 8] = s[8] ? 8'hFF : s[7:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

[rtl/core/sab_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module sab_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

[rtl/core/sab_front.sv]
// Front end: accepts actions, clamps blit sizes, computes pixel count, queues commands.
// Depends on sab_pkg.
`default_nettype none
module sab_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 action_i,
  input  wire logic [15:0]                address_i,
  input  wire logic [31:0]                data_i,
  input  wire logic [13:0]                src_origin_i,
  input  wire logic [15:0]                dst_start_i,
  input  wire logic [7:0]                 rect_width_i,
  input  wire logic [7:0]                 rect_rows_i,
  input  wire logic [10:0]                src_pitch_i,
  output logic                            cmd_valid_o,
  input  wire logic                       cmd_ready_i,
  output sab_pkg::cmd_t                   cmd_o
);
  sab_pkg::cmd_t q_mem [sab_pkg::QDepth];
  logic [0:0] wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  sab_pkg::cmd_t c;
  logic [7:0] w, h;
  logic push, pop;

  always_comb begin
    w = (rect_width_i > sab_pkg::MaxSide) ? sab_pkg::MaxSide : rect_width_i;
    h = (rect_rows_i > sab_pkg::MaxSide) ? sab_pkg::MaxSide : rect_rows_i;
    c.action     = sab_pkg::action_e'(action_i);
    c.address    = address_i;
    c.data       = data_i;
    c.src_origin = src_origin_i;
    c.dst_start  = dst_start_i;
    c.width      = w;
    c.rows       = h;
    c.src_pitch  = src_pitch_i;
    c.count      = {8'b0, w} * {8'b0, h};
  end

  assign in_ready_o  = (cnt_q != 2'(sab_pkg::QDepth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;
  assign wr_d = push ? wr_q + 1'b1 : wr_q;
  assign rd_d = pop ? rd_q + 1'b1 : rd_q;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= c;
    end
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(sab_pkg::QDepth)) else $error("queue overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("pop while empty");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
`endif
endmodule
`default_nettype wire

[rtl/core/sab_back.sv]
// Back end: executes queued commands against the source and destination RAMs.
// Depends on sab_pkg and sab_ram.
`default_nettype none
module sab_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire sab_pkg::cmd_t cmd_i,
  input  wire logic [10:0]   dest_pitch_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [31:0]        read_data_o,
  output logic [15:0]        pixels_done_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_BRD  = 3'd2;
  localparam logic [2:0] S_BWAIT= 3'd3;
  localparam logic [2:0] S_BWR  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] st_q, st_d;
  sab_pkg::cmd_t cmd_q;
  logic [7:0] col_q, col_d, row_q, row_d;
  logic [sab_pkg::SrcAw-1:0] srow_q, srow_d, scur;
  logic [sab_pkg::DestAw-1:0] drow_q, drow_d, dcur;
  logic [31:0] rd_q, rd_d;
  logic [15:0] pd_q, pd_d;
  logic ov_q, ov_d;

  logic s_we, d_we;
  logic [sab_pkg::SrcAw-1:0] s_addr;
  logic [sab_pkg::DestAw-1:0] d_addr;
  logic [31:0] s_wdata, d_wdata, s_rdata, d_rdata;
  logic accept;

  assign scur = srow_q + sab_pkg::SrcAw'(col_q);
  assign dcur = drow_q + sab_pkg::DestAw'(col_q);

  sab_ram #(.Width(32), .Depth(sab_pkg::SourceWords)) u_src (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wdata), .rdata_o(s_rdata));
  sab_ram #(.Width(32), .Depth(sab_pkg::DestWords)) u_dst (
    .clk_i, .we_i(d_we), .addr_i(d_addr), .wdata_i(d_wdata), .rdata_o(d_rdata));

  assign cmd_ready_o = (st_q == S_IDLE) && (!ov_q || out_ready_i);
  assign accept = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = ov_q;
  assign read_data_o = rd_q;
  assign pixels_done_o = pd_q;

  always_comb begin
    st_d = st_q; col_d = col_q; row_d = row_q; srow_d = srow_q; drow_d = drow_q;
    rd_d = rd_q; pd_d = pd_q; ov_d = ov_q;
    s_we = 1'b0; d_we = 1'b0;
    s_addr = scur; d_addr = dcur;
    s_wdata = cmd_i.data; d_wdata = sab_pkg::add_sat(s_rdata, d_rdata);
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          rd_d = '0; pd_d = '0;
          unique case (cmd_i.action)
            sab_pkg::ACT_WR_SRC: begin
              s_we = 1'b1; s_addr = cmd_i.address[sab_pkg::SrcAw-1:0]; ov_d = 1'b1;
            end
            sab_pkg::ACT_WR_DST: begin
              d_we = 1'b1; d_addr = cmd_i.address[sab_pkg::DestAw-1:0];
              d_wdata = cmd_i.data; ov_d = 1'b1;
            end
            sab_pkg::ACT_RD_DST: begin
              d_addr = cmd_i.address[sab_pkg::DestAw-1:0]; st_d = S_RD;
            end
            default: begin
              col_d = '0; row_d = '0;
              srow_d = cmd_i.src_origin; drow_d = cmd_i.dst_start;
              if (cmd_i.width == '0 || cmd_i.rows == '0) begin
                ov_d = 1'b1;
              end else begin
                st_d = S_BRD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        if (!ov_q) begin
          rd_d = d_rdata; ov_d = 1'b1; st_d = S_IDLE;
        end
      end
      S_BRD: st_d = S_BWAIT;
      S_BWAIT: st_d = S_BWR;
      S_BWR: begin
        d_we = 1'b1;
        if (col_q == cmd_q.width - 8'd1) begin
          col_d = '0;
          srow_d = srow_q + sab_pkg::SrcAw'(cmd_q.src_pitch);
          drow_d = drow_q + sab_pkg::DestAw'(dest_pitch_i);
          if (row_q == cmd_q.rows - 8'd1) begin
            row_d = cmd_q.rows;
            st_d = S_OUT;
          end else begin
            row_d = row_q + 8'd1;
            st_d = S_BRD;
          end
        end else begin
          col_d = col_q + 8'd1;
          st_d = S_BRD;
        end
      end
      S_OUT: begin
        if (!ov_q) begin
          pd_d = cmd_q.count; ov_d = 1'b1; st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ov_q <= 1'b0;
      col_q <= '0; row_q <= '0; srow_q <= '0; drow_q <= '0;
    end else begin
      st_q <= st_d; ov_q <= ov_d;
      col_q <= col_d; row_q <= row_d; srow_q <= srow_d; drow_q <= drow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    rd_q <= rd_d;
    pd_q <= pd_d;
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(rd_q) && $stable(pd_q))
    else $error("result changed while stalled");
  a_wr_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_BWR |-> $past(st_q) == S_BWAIT) else $error("walk order");
  a_one_hot_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (rd_q == '0 || pd_q == '0)) else $error("both result fields set");
`endif
endmodule
`default_nettype wire

[rtl/core/saturating_additive_blitter_unit.sv]
// Top level of the saturating additive blitter: front queue, back executor, pitch register.
// Depends on sab_pkg, sab_front, sab_back.
// In the back end a write completes on acceptance and a read passes through S_RD; a blit
// walks each pixel through S_BRD (read both RAMs), S_BWAIT (wait for registered data) and
// S_BWR (write back), then reports from S_OUT. An empty rectangle reports on acceptance.
// A two-entry command queue lets the front accept while the back walks.
`default_nettype none
module saturating_additive_blitter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [10:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] address_i,
  input  wire logic [31:0] data_i,
  input  wire logic [13:0] src_origin_i,
  input  wire logic [15:0] dst_start_i,
  input  wire logic [7:0]  rect_width_i,
  input  wire logic [7:0]  rect_rows_i,
  input  wire logic [10:0] src_pitch_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      read_data_o,
  output logic [15:0]      pixels_done_o
);
  logic [10:0] dest_pitch_q;
  logic cmd_valid, cmd_ready;
  sab_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_pitch_q <= sab_pkg::DestPitchRst;
    end else if (cfg_valid_i) begin
      dest_pitch_q <= cfg_data_i;
    end
  end

  sab_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .address_i, .data_i,
    .src_origin_i, .dst_start_i, .rect_width_i, .rect_rows_i, .src_pitch_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd));

  sab_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .dest_pitch_i(dest_pitch_q), .out_valid_o, .out_ready_i, .read_data_o,
    .pixels_done_o);
endmodule
`default_nettype wire
